/* rtl/core/rpe_pkg.sv */
// ----------------------------------------------------------------------------
// rpe_pkg : shared types, constants and table builders
// Fixed-point formats, angle constants and the arctangent table for the
// rotary position embedding datapath. Also holds the constant functions that
// build the frequency table and the CORDIC gain during elaboration.
// ----------------------------------------------------------------------------
package rpe_pkg;

   localparam int POS_W        = 12;
   localparam int PAIR_W       = 8;
   localparam int SAMPLE_W     = 16;
   localparam int KEY_WIDTH_W  = 10;
   localparam int REQ_TDATA_W  = 88;
   localparam int RSP_TDATA_W  = 64;
   localparam int PAIR_COUNT   = 256;
   localparam int FRAC_W       = 30;
   localparam int FREQ_W       = FRAC_W + 1;
   localparam int PROD_W       = POS_W + FREQ_W;
   localparam int ANGLE_W      = 33;
   localparam int REDUCE_STEPS = 10;
   localparam int CORDIC_W     = 34;
   localparam int MUL_W        = SAMPLE_W + CORDIC_W;
   localparam int ACC_W        = MUL_W + 2;
   localparam int ATAN_LEN     = 24;
   localparam int TAYLOR_TERMS = 24;

   localparam int HEAD_SIZE_DEF    = 64;
   localparam int VEC_DIM_DEF      = 512;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam longint unsigned Q30_ONE      = 64'd1 << FRAC_W;
   localparam longint unsigned LN10K_Q30    = 64'd9889527671;
   localparam longint unsigned LN2_Q30      = 64'd744261118;
   localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
   localparam longint unsigned PI_Q30       = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
   // upper fold limit: angles at or above it wrap to negative without a flip
   localparam longint unsigned THREE_HALF_PI_Q30 = TWO_PI_Q30 - HALF_PI_Q30;

   localparam longint unsigned ATAN_Q30 [ATAN_LEN] = '{
      64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
      64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
      64'd1048576, 64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768,
      64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256,
      64'd128
   };

   typedef logic        [POS_W-1:0]       pos_type;
   typedef logic        [PAIR_W-1:0]      pair_type;
   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic        [KEY_WIDTH_W-1:0] key_width_type;
   typedef logic        [FREQ_W-1:0]      freq_type;
   typedef logic        [PROD_W-1:0]      prod_type;
   typedef logic        [ANGLE_W-1:0]     angle_type;
   typedef logic signed [CORDIC_W-1:0]    cordic_type;
   typedef logic signed [MUL_W-1:0]       mul_type;
   typedef logic signed [ACC_W-1:0]       acc_type;

   typedef freq_type freq_rom_type [PAIR_COUNT];

   localparam key_width_type KEY_WIDTH_RESET = key_width_type'(512);

   // item payload and routing flags that ride along the pipeline
   typedef struct packed {
      logic       bypass;    // pair beyond the vector: nothing rotated
      logic       key_rot;   // key pair rotated as well
      sample_type q_even;
      sample_type q_odd;
      sample_type k_even;
      sample_type k_odd;
   } side_type;

   // restoring long division, elaboration only
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              i;
      quo = 64'd0;
      rem = 64'd0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint unsigned isqrt64(input longint unsigned val);
      longint unsigned res;
      longint unsigned bitv;
      longint unsigned n;
      n    = val;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned cordic_gain(input int steps);
      longint unsigned k;
      longint unsigned s;
      int              i;
      k = Q30_ONE;
      for (i = 0; i < steps && i < ATAN_LEN; i++) begin
         s = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
         k = udiv64((k << FRAC_W) + (s >> 1), s);
      end
      return k;
   endfunction

   // 10000^(-offset/head_len) in Q30: range reduction by ln2, Taylor series
   function automatic freq_type freq_q30(input int offset, input int head_len);
      longint unsigned x;
      longint unsigned k;
      longint unsigned r;
      longint unsigned term;
      longint          sum;
      int              n;
      x    = udiv64(LN10K_Q30 * longint'(offset), longint'(head_len));
      k    = udiv64(x, LN2_Q30);
      r    = x - k * LN2_Q30;
      sum  = longint'(Q30_ONE);
      term = Q30_ONE;
      for (n = 1; n <= TAYLOR_TERMS && term != 64'd0; n++) begin
         term = udiv64((term * r) >> FRAC_W, longint'(n));
         sum  = n[0] ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (k > 64'd62) return freq_type'(0);
      return freq_type'(sum >>> k);
   endfunction

   // indexed by pair number; offset in head is (2*pair) mod head_len
   function automatic freq_rom_type build_freq_rom(input int head_len);
      freq_rom_type    rom;
      longint unsigned elem;
      longint unsigned offset;
      int              p;
      for (p = 0; p < PAIR_COUNT; p++) begin
         elem   = 64'd2 * longint'(p);
         offset = elem - longint'(head_len) * udiv64(elem, longint'(head_len));
         rom[p] = freq_q30(int'(offset), head_len);
      end
      return rom;
   endfunction

endpackage

/* rtl/core/rotary_position_embedding.sv */
// Throughput: one pair per cycle while rsp_tready does not stall the pipe;
//   every stage is one register and the multiplier, reduction cells and
//   CORDIC cells each take a new item per cycle.
// Reset: synchronous, clears all stage valids and loads key_width with 512.
// ----------------------------------------------------------------------------
// rotary_position_embedding : RoPE rotation of one query and one key pair
// Frequency lookup, position multiply, modulo-2pi reduction cells, quadrant
// fold, a row of CORDIC cells and the pair rotation with saturation.
// ----------------------------------------------------------------------------
module rotary_position_embedding #(
   parameter int HEAD_SIZE    = rpe_pkg::HEAD_SIZE_DEF,
   parameter int VEC_DIM      = rpe_pkg::VEC_DIM_DEF,
   parameter int CORDIC_STEPS = rpe_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: position, pair_index, query_even, query_odd, key_even, key_odd
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rpe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: query_even_out, query_odd_out, key_even_out, key_odd_out
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rpe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // response: key_was_rotated
   output logic                             rsp_tuser,
   // key_width register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rpe_pkg::KEY_WIDTH_W-1:0]  csr_data
);

   localparam rpe_pkg::freq_rom_type FREQ_ROM = rpe_pkg::build_freq_rom(HEAD_SIZE);
   localparam rpe_pkg::cordic_type   GAIN     =
      rpe_pkg::cordic_type'(rpe_pkg::cordic_gain(CORDIC_STEPS));
   localparam int RED_N = rpe_pkg::REDUCE_STEPS;

   // key width register
   rpe_pkg::key_width_type key_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_width_ff <= rpe_pkg::KEY_WIDTH_RESET;
      end else if (csr_valid) begin
         key_width_ff <= csr_data;
      end
   end

   // request fields
   rpe_pkg::pos_type      req_pos;
   rpe_pkg::pair_type     req_pair;
   logic [rpe_pkg::PAIR_W:0] req_elem;
   rpe_pkg::side_type     side_a_in;

   assign req_pos  = req_tdata[11:0];
   assign req_pair = req_tdata[19:12];
   assign req_elem = {req_pair, 1'b0};

   always_comb begin
      side_a_in.q_even  = req_tdata[35:20];
      side_a_in.q_odd   = req_tdata[51:36];
      side_a_in.k_even  = req_tdata[67:52];
      side_a_in.k_odd   = req_tdata[83:68];
      side_a_in.bypass  = 32'(req_elem) >= 32'(VEC_DIM);
      side_a_in.key_rot = !side_a_in.bypass && ({1'b0, req_elem} < key_width_ff);
   end

   // stage A: frequency lookup
   logic              a_valid_ff;
   logic              a_ready;
   rpe_pkg::pos_type  pos_a_ff;
   rpe_pkg::freq_type freq_a_ff;
   rpe_pkg::side_type side_a_ff;

   // stage B: angle product
   logic              b_valid_ff;
   logic              b_ready;
   rpe_pkg::prod_type prod_b_ff;
   rpe_pkg::side_type side_b_ff;

   assign req_tready = a_ready;
   assign a_ready    = !a_valid_ff || b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_tvalid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && a_ready) begin
         pos_a_ff  <= req_pos;
         freq_a_ff <= FREQ_ROM[req_pair];
         side_a_ff <= side_a_in;
      end
      if (a_valid_ff && b_ready) begin
         prod_b_ff <= rpe_pkg::prod_type'(pos_a_ff) * rpe_pkg::prod_type'(freq_a_ff);
         side_b_ff <= side_a_ff;
      end
   end

   // modulo-2pi reduction row
   logic              red_valid [RED_N+1];
   logic              red_ready [RED_N+1];
   rpe_pkg::prod_type red_acc   [RED_N+1];
   rpe_pkg::side_type red_side  [RED_N+1];

   assign red_valid[0] = b_valid_ff;
   assign red_acc[0]   = prod_b_ff;
   assign red_side[0]  = side_b_ff;
   assign b_ready      = red_ready[0];

   for (genvar g = 0; g < RED_N; g++) begin : g_reduce
      rpe_reduce_cell #(
         .SHIFT (RED_N - 1 - g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (red_valid[g]),
         .up_ready (red_ready[g]),
         .up_acc   (red_acc[g]),
         .up_side  (red_side[g]),
         .dn_valid (red_valid[g+1]),
         .dn_ready (red_ready[g+1]),
         .dn_acc   (red_acc[g+1]),
         .dn_side  (red_side[g+1])
      );
   end

   // quadrant fold into [-pi/2, pi/2]; a half-turn shift flips cos and sin
   logic                f_valid_ff;
   logic                f_ready;
   rpe_pkg::angle_type  ang_f;
   rpe_pkg::cordic_type ang_s;
   rpe_pkg::cordic_type z_f_in;
   logic                neg_f_in;
   rpe_pkg::cordic_type z_f_ff;
   logic                neg_f_ff;
   rpe_pkg::side_type   side_f_ff;

   // CORDIC row
   logic                cor_valid [CORDIC_STEPS+1];
   logic                cor_ready [CORDIC_STEPS+1];
   rpe_pkg::cordic_type cor_x     [CORDIC_STEPS+1];
   rpe_pkg::cordic_type cor_y     [CORDIC_STEPS+1];
   rpe_pkg::cordic_type cor_z     [CORDIC_STEPS+1];
   logic                cor_neg   [CORDIC_STEPS+1];
   rpe_pkg::side_type   cor_side  [CORDIC_STEPS+1];

   assign ang_f             = red_acc[RED_N][rpe_pkg::ANGLE_W-1:0];
   assign ang_s             = rpe_pkg::cordic_type'({1'b0, ang_f});
   assign f_ready           = !f_valid_ff || cor_ready[0];
   assign red_ready[RED_N]  = f_ready;

   always_comb begin
      priority if (ang_f <= rpe_pkg::angle_type'(rpe_pkg::HALF_PI_Q30)) begin
         z_f_in   = ang_s;
         neg_f_in = 1'b0;
      end else if (ang_f < rpe_pkg::angle_type'(rpe_pkg::THREE_HALF_PI_Q30)) begin
         z_f_in   = ang_s - rpe_pkg::cordic_type'(rpe_pkg::PI_Q30);
         neg_f_in = 1'b1;
      end else begin
         z_f_in   = ang_s - rpe_pkg::cordic_type'(rpe_pkg::TWO_PI_Q30);
         neg_f_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_ready) begin
         f_valid_ff <= red_valid[RED_N];
      end
   end

   always_ff @(posedge clock) begin
      if (red_valid[RED_N] && f_ready) begin
         z_f_ff    <= z_f_in;
         neg_f_ff  <= neg_f_in;
         side_f_ff <= red_side[RED_N];
      end
   end

   assign cor_valid[0] = f_valid_ff;
   assign cor_x[0]     = GAIN;
   assign cor_y[0]     = rpe_pkg::cordic_type'(0);
   assign cor_z[0]     = z_f_ff;
   assign cor_neg[0]   = neg_f_ff;
   assign cor_side[0]  = side_f_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      rpe_cordic_cell #(
         .STEP (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cor_valid[g]),
         .up_ready (cor_ready[g]),
         .up_x     (cor_x[g]),
         .up_y     (cor_y[g]),
         .up_z     (cor_z[g]),
         .up_neg   (cor_neg[g]),
         .up_side  (cor_side[g]),
         .dn_valid (cor_valid[g+1]),
         .dn_ready (cor_ready[g+1]),
         .dn_x     (cor_x[g+1]),
         .dn_y     (cor_y[g+1]),
         .dn_z     (cor_z[g+1]),
         .dn_neg   (cor_neg[g+1]),
         .dn_side  (cor_side[g+1])
      );
   end

   rpe_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (cor_valid[CORDIC_STEPS]),
      .up_ready   (cor_ready[CORDIC_STEPS]),
      .up_cos     (cor_x[CORDIC_STEPS]),
      .up_sin     (cor_y[CORDIC_STEPS]),
      .up_neg     (cor_neg[CORDIC_STEPS]),
      .up_side    (cor_side[CORDIC_STEPS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/core/rpe_reduce_cell.sv */
// ----------------------------------------------------------------------------
// rpe_reduce_cell : one step of the modulo-2pi angle reduction
// Takes off 2pi shifted left by SHIFT when the angle is at least that large.
// A row of these, largest shift first, leaves the angle in [0, 2pi).
// ----------------------------------------------------------------------------
module rpe_reduce_cell #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rpe_pkg::prod_type    up_acc,
   input  rpe_pkg::side_type    up_side,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rpe_pkg::prod_type    dn_acc,
   output rpe_pkg::side_type    dn_side
);

   localparam rpe_pkg::prod_type THRESH = rpe_pkg::prod_type'(rpe_pkg::TWO_PI_Q30 << SHIFT);

   logic              valid_ff;
   rpe_pkg::prod_type acc_ff;
   rpe_pkg::prod_type acc_in;
   rpe_pkg::side_type side_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign acc_in   = (up_acc >= THRESH) ? up_acc - THRESH : up_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         acc_ff  <= acc_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_acc   = acc_ff;
   assign dn_side  = side_ff;

endmodule

/* rtl/core/rpe_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rpe_cordic_cell : one CORDIC micro-rotation
// Rotation mode, direction from the sign of the residual angle. Shifts are
// arithmetic, so they round toward minus infinity.
// ----------------------------------------------------------------------------
module rpe_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rpe_pkg::cordic_type  up_x,
   input  rpe_pkg::cordic_type  up_y,
   input  rpe_pkg::cordic_type  up_z,
   input  logic                 up_neg,
   input  rpe_pkg::side_type    up_side,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rpe_pkg::cordic_type  dn_x,
   output rpe_pkg::cordic_type  dn_y,
   output rpe_pkg::cordic_type  dn_z,
   output logic                 dn_neg,
   output rpe_pkg::side_type    dn_side
);

   localparam rpe_pkg::cordic_type ATAN = rpe_pkg::cordic_type'(rpe_pkg::ATAN_Q30[STEP]);

   logic                valid_ff;
   rpe_pkg::cordic_type x_ff, y_ff, z_ff;
   rpe_pkg::cordic_type x_in, y_in, z_in;
   rpe_pkg::cordic_type dx, dy;
   logic                z_neg;
   logic                neg_ff;
   rpe_pkg::side_type   side_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign z_neg    = up_z[rpe_pkg::CORDIC_W-1];
   assign dx       = up_y >>> STEP;
   assign dy       = up_x >>> STEP;

   always_comb begin
      if (z_neg) begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ATAN;
      end else begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         neg_ff  <= up_neg;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_neg   = neg_ff;
   assign dn_side  = side_ff;

endmodule

/* rtl/core/rpe_rotate.sv */
// ----------------------------------------------------------------------------
// rpe_rotate : pair rotation and output register
// First stage forms the eight sample-by-cos/sin products, second stage sums,
// applies the half-turn flip, rounds half up, saturates and selects the
// rotated or passed-through values into the response register.
// ----------------------------------------------------------------------------
module rpe_rotate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  rpe_pkg::cordic_type           up_cos,
   input  rpe_pkg::cordic_type           up_sin,
   input  logic                          up_neg,
   input  rpe_pkg::side_type             up_side,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rpe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                          rsp_tuser
);

   localparam rpe_pkg::acc_type ROUND  = rpe_pkg::acc_type'(rpe_pkg::Q30_ONE >> 1);
   localparam rpe_pkg::acc_type SAT_HI = rpe_pkg::acc_type'(32767);
   localparam rpe_pkg::acc_type SAT_LO = rpe_pkg::acc_type'(-32768);
   localparam rpe_pkg::acc_type ZERO   = rpe_pkg::acc_type'(0);

   function automatic rpe_pkg::sample_type sat_round(input rpe_pkg::acc_type acc);
      rpe_pkg::acc_type sh;
      sh = (acc + ROUND) >>> rpe_pkg::FRAC_W;
      if (sh > SAT_HI) sh = SAT_HI;
      else if (sh < SAT_LO) sh = SAT_LO;
      return rpe_pkg::sample_type'(sh);
   endfunction

   // product stage
   logic              m_valid_ff;
   logic              m_ready;
   rpe_pkg::mul_type  p_qec_ff, p_qos_ff, p_qes_ff, p_qoc_ff;
   rpe_pkg::mul_type  p_kec_ff, p_kos_ff, p_kes_ff, p_koc_ff;
   logic              neg_m_ff;
   rpe_pkg::side_type side_m_ff;

   // response register
   logic                rsp_valid_ff;
   rpe_pkg::sample_type qe_out_ff, qo_out_ff, ke_out_ff, ko_out_ff;
   logic                key_rot_ff;
   rpe_pkg::sample_type qe_rot, qo_rot, ke_rot, ko_rot;
   rpe_pkg::sample_type qe_out_in, qo_out_in, ke_out_in, ko_out_in;

   assign up_ready = !m_valid_ff || m_ready;
   assign m_ready  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (up_ready) begin
         m_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         p_qec_ff  <= rpe_pkg::mul_type'(up_side.q_even) * rpe_pkg::mul_type'(up_cos);
         p_qos_ff  <= rpe_pkg::mul_type'(up_side.q_odd)  * rpe_pkg::mul_type'(up_sin);
         p_qes_ff  <= rpe_pkg::mul_type'(up_side.q_even) * rpe_pkg::mul_type'(up_sin);
         p_qoc_ff  <= rpe_pkg::mul_type'(up_side.q_odd)  * rpe_pkg::mul_type'(up_cos);
         p_kec_ff  <= rpe_pkg::mul_type'(up_side.k_even) * rpe_pkg::mul_type'(up_cos);
         p_kos_ff  <= rpe_pkg::mul_type'(up_side.k_odd)  * rpe_pkg::mul_type'(up_sin);
         p_kes_ff  <= rpe_pkg::mul_type'(up_side.k_even) * rpe_pkg::mul_type'(up_sin);
         p_koc_ff  <= rpe_pkg::mul_type'(up_side.k_odd)  * rpe_pkg::mul_type'(up_cos);
         neg_m_ff  <= up_neg;
         side_m_ff <= up_side;
      end
   end

   // the half-turn flip negates cos and sin, so it negates both sums
   always_comb begin
      if (neg_m_ff) begin
         qe_rot = sat_round(rpe_pkg::acc_type'(p_qos_ff) - rpe_pkg::acc_type'(p_qec_ff));
         qo_rot = sat_round(ZERO - rpe_pkg::acc_type'(p_qes_ff)
                                 - rpe_pkg::acc_type'(p_qoc_ff));
         ke_rot = sat_round(rpe_pkg::acc_type'(p_kos_ff) - rpe_pkg::acc_type'(p_kec_ff));
         ko_rot = sat_round(ZERO - rpe_pkg::acc_type'(p_kes_ff)
                                 - rpe_pkg::acc_type'(p_koc_ff));
      end else begin
         qe_rot = sat_round(rpe_pkg::acc_type'(p_qec_ff) - rpe_pkg::acc_type'(p_qos_ff));
         qo_rot = sat_round(rpe_pkg::acc_type'(p_qes_ff) + rpe_pkg::acc_type'(p_qoc_ff));
         ke_rot = sat_round(rpe_pkg::acc_type'(p_kec_ff) - rpe_pkg::acc_type'(p_kos_ff));
         ko_rot = sat_round(rpe_pkg::acc_type'(p_kes_ff) + rpe_pkg::acc_type'(p_koc_ff));
      end
   end

   always_comb begin
      qe_out_in = side_m_ff.bypass  ? side_m_ff.q_even : qe_rot;
      qo_out_in = side_m_ff.bypass  ? side_m_ff.q_odd  : qo_rot;
      ke_out_in = side_m_ff.key_rot ? ke_rot : side_m_ff.k_even;
      ko_out_in = side_m_ff.key_rot ? ko_rot : side_m_ff.k_odd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (m_ready) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_valid_ff && m_ready) begin
         qe_out_ff  <= qe_out_in;
         qo_out_ff  <= qo_out_in;
         ke_out_ff  <= ke_out_in;
         ko_out_ff  <= ko_out_in;
         key_rot_ff <= side_m_ff.key_rot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ko_out_ff, ke_out_ff, qo_out_ff, qe_out_ff};
   assign rsp_tuser  = key_rot_ff;

endmodule

/* rtl/core/rpe_checker.sv */
// ----------------------------------------------------------------------------
// rpe_checker : port-level checks for rotary_position_embedding
// Tracks transfers in flight and checks reset, stall and flow behaviour.
// ----------------------------------------------------------------------------
module rpe_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rpe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser
);

   localparam int CNT_W = 8;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [CNT_W-1:0] pending_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         pending_ff <= pending_ff + CNT_W'(1);
      end else if (rsp_xfer && !req_xfer) begin
         pending_ff <= pending_ff - CNT_W'(1);
      end
   end

   // nothing comes out of the pipe straight after a reset cycle
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // every response transfer is matched by an earlier request transfer
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pending_ff != '0)
      else $error("response without a pending request");

   // a free output side lets the whole pipe move
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request side stalled while response side is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind rotary_position_embedding rpe_checker u_checker (.*);
